// File: rtl/tbfc_pkg.sv
// Shared types and constants for the three-byte to four-character encoder.
// No dependencies; every other file in rtl/ except tbfc_if.sv imports this package.
package tbfc_pkg;

   // Default depth of the group queue between front and back end
   localparam int unsigned TBFC_QUEUE_DEPTH = 2;

   // Character encoding constants
   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned GROUP_SIZE = 3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // Number of bytes held in the current group (0..2)
   typedef logic [1:0] grp_pos_type;

   // One encoded group: header plus up to three data characters
   typedef struct packed {
      char_type [GROUP_SIZE:0] chars;     // chars[0] is the header
      logic [1:0]              present;   // bytes in group, 1..3 (also last char index)
      logic                    last;      // group closes the packet
   } tbfc_job_type;

   // Header: start mark in bit 6, then top bit pairs of the three bytes
   function automatic char_type header_char(input byte_type b1, input byte_type b2,
                                            input byte_type b3, input logic start);
      header_char = {~start, b1[7:6], b2[7:6], b3[7:6]};
   endfunction

   // Data character: 0x40 plus the low six bits
   function automatic char_type data_char(input byte_type b);
      data_char = {1'b1, b[5:0]};
   endfunction

endpackage

// File: rtl/tbfc_if.sv
// Valid/ready channel interfaces for the encoder's byte input and character output.
// Standalone; payload widths match tbfc_pkg.
interface tbfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tbfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       run_last;
   logic       packet_end;

   modport source (output valid, output out_char, output run_last, output packet_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input packet_end,
                   output ready);
endinterface

// File: rtl/three_byte_to_four_char_encoder_top.sv
// Top level of the three-byte to four-character encoder.
// Depends on tbfc_pkg, tbfc_if, tbfc_front, tbfc_queue and tbfc_back.
//
// Encodes packet bytes, three at a time, into seven-bit characters: a header holding
// the top two bits of each byte, then one character per byte with its low six bits,
// each carrying 0x40; a partial final group gives two or three characters and the
// first character of every packet has bit 6 clear. The front end takes one byte per
// cycle while the QUEUE_DEPTH-entry queue has room and hands each finished group to
// it; the back end sends one character per cycle while the output is ready, through
// a registered output, so throughput is set by the output port: four characters per
// three-byte group. A byte that does not close a group gives no character; the header
// of a group goes from the byte that closes it into a queue slot and then into the
// output register before it appears on the output.
module three_byte_to_four_char_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = tbfc_pkg::TBFC_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   tbfc_req_if.sink   req_chan,
   tbfc_rsp_if.source rsp_chan
);
   import tbfc_pkg::*;

   logic         push_valid, push_ready;
   tbfc_job_type push_data;
   logic         pop_valid, pop_ready;
   tbfc_job_type pop_data;

   tbfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (push_valid),
      .job_data  (push_data),
      .job_ready (push_ready)
   );

   tbfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tbfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: rtl/tbfc_front.sv
// Front end: collects input bytes into groups of up to three and builds one encoded job per group.
// Depends on tbfc_pkg and tbfc_req_if.
module tbfc_front (
   input  logic                  clock,
   input  logic                  reset,
   tbfc_req_if.sink              req_chan,
   output logic                  job_valid,
   output tbfc_pkg::tbfc_job_type job_data,
   input  logic                  job_ready
);
   import tbfc_pkg::*;

   grp_pos_type pos_ff, pos_in;
   byte_type    first_ff, first_in;
   byte_type    second_ff, second_in;
   logic        start_ff, start_in;

   logic        accept;
   logic        complete;
   logic [1:0]  present;
   byte_type    b1, b2, b3;

   // Pick the group bytes; a position of three acts like two
   always_comb begin
      unique case (pos_ff)
         2'd0: begin
            b1 = req_chan.data_byte; b2 = '0; b3 = '0; present = 2'd1;
         end
         2'd1: begin
            b1 = first_ff; b2 = req_chan.data_byte; b3 = '0; present = 2'd2;
         end
         default: begin
            b1 = first_ff; b2 = second_ff; b3 = req_chan.data_byte; present = 2'd3;
         end
      endcase
   end

   assign complete       = (present == 2'd3) || req_chan.last_byte;
   assign req_chan.ready = job_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign job_valid      = req_chan.valid && complete;

   // Build the job for a finished group
   always_comb begin
      job_data.chars[0] = header_char(b1, b2, b3, start_ff);
      job_data.chars[1] = data_char(b1);
      job_data.chars[2] = data_char(b2);
      job_data.chars[3] = data_char(b3);
      job_data.present  = present;
      job_data.last     = req_chan.last_byte;
   end

   // Hold partial group bytes, clear after each finished group
   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      second_in = second_ff;
      start_in  = start_ff;
      if (accept) begin
         if (complete) begin
            pos_in    = '0;
            first_in  = '0;
            second_in = '0;
            start_in  = req_chan.last_byte;
         end else begin
            if (pos_ff == 2'd0) begin
               first_in = req_chan.data_byte;
            end else begin
               second_in = req_chan.data_byte;
            end
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         start_ff  <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         start_ff  <= start_in;
      end
   end

endmodule

// File: rtl/tbfc_queue.sv
// Short queue of encoded group jobs between front and back end.
// Depends on tbfc_pkg; DEPTH must be at least 2.
module tbfc_queue #(
   parameter int unsigned DEPTH = tbfc_pkg::TBFC_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  tbfc_pkg::tbfc_job_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output tbfc_pkg::tbfc_job_type pop_data
);
   import tbfc_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   tbfc_job_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store slot payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/tbfc_back.sv
// Back end: steps through one job's characters and drives them into the output register.
// Depends on tbfc_pkg and tbfc_rsp_if.
module tbfc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  tbfc_pkg::tbfc_job_type job_data,
   tbfc_rsp_if.source             rsp_chan
);
   import tbfc_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   char_type   char_ff, char_in;
   logic       run_last_ff, run_last_in;
   logic       end_ff, end_in;

   logic       load;
   logic       final_char;

   assign load       = job_valid && (!valid_ff || rsp_chan.ready);
   assign final_char = (idx_ff == job_data.present);
   assign job_ready  = load && final_char;

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.out_char   = char_ff;
   assign rsp_chan.run_last   = run_last_ff;
   assign rsp_chan.packet_end = end_ff;

   // Load the next character when the output register is free or being drained
   always_comb begin
      idx_in      = idx_ff;
      char_in     = char_ff;
      run_last_in = run_last_ff;
      end_in      = end_ff;
      valid_in    = valid_ff && !rsp_chan.ready;
      if (load) begin
         valid_in    = 1'b1;
         char_in     = job_data.chars[idx_ff];
         run_last_in = final_char;
         end_in      = final_char && job_data.last;
         idx_in      = final_char ? '0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      run_last_ff <= run_last_in;
      end_ff      <= end_in;
   end

endmodule

// File: bench/tb.sv
// Self-checking bench for three_byte_to_four_char_encoder_top: drives packet bytes,
// predicts the encoded characters and checks every character transfer in order.
// Depends on tbfc_pkg, tbfc_if and the encoder RTL.
module tb;
   import tbfc_pkg::*;

   localparam int unsigned RANDOM_BYTES = 200;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned LONG_HOLD    = 250;
   localparam int unsigned DIR_ROWS     = 25;

   // One expected character with its marks
   typedef struct packed {
      char_type ch;
      logic     run_last;
      logic     pkt_end;
   } enc_char_type;

   // Directed row: typed rows carry the expected characters, others use the predictor
   typedef struct packed {
      byte_type   data;
      logic       last;
      logic       typed;
      logic [2:0] n;
      char_type   c0;
      char_type   c1;
      char_type   c2;
      char_type   c3;
   } stim_row_type;

   logic clock;
   logic reset;

   tbfc_req_if req_chan ();
   tbfc_rsp_if rsp_chan ();

   three_byte_to_four_char_encoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state
   grp_pos_type grp_pos;
   byte_type    held_first;
   byte_type    held_second;
   logic        at_start;

   enc_char_type pending_chars [$];
   int unsigned  err_count;
   int unsigned  got_count;
   int unsigned  cycle_count;

   stim_row_type dir_tab [0:DIR_ROWS-1] = '{
      // single bytes at packet start: header has bit 6 clear
      '{8'h00, 1'b1, 1'b1, 3'd2, 7'h00, 7'h40, 7'h00, 7'h00},
      '{8'hFF, 1'b1, 1'b1, 3'd2, 7'h30, 7'h7F, 7'h00, 7'h00},
      // full group of all ones
      '{8'hFF, 1'b0, 1'b1, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'hFF, 1'b0, 1'b1, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'hFF, 1'b1, 1'b1, 3'd4, 7'h3F, 7'h7F, 7'h7F, 7'h7F},
      // two-byte packet: absent third byte counts as zero
      '{8'h80, 1'b0, 1'b1, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h41, 1'b1, 1'b1, 3'd3, 7'h24, 7'h40, 7'h41, 7'h00},
      // full first group, then a partial group without the start mark
      '{8'hC0, 1'b0, 1'b1, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h00, 1'b0, 1'b1, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h3F, 1'b0, 1'b1, 3'd4, 7'h30, 7'h40, 7'h40, 7'h7F},
      '{8'h55, 1'b0, 1'b1, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'hAA, 1'b1, 1'b1, 3'd3, 7'h58, 7'h55, 7'h6A, 7'h00},
      // walking ones over a longer packet, then three short packets
      '{8'h01, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h02, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h04, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h08, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h10, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h20, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h40, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h80, 1'b1, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h7E, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'hBD, 1'b1, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'hE7, 1'b1, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'hFF, 1'b0, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00},
      '{8'h00, 1'b1, 1'b0, 3'd0, 7'h00, 7'h00, 7'h00, 7'h00}
   };

   // Clock: period 4
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Reset held from the start, released once
   initial begin
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[three_byte_to_four_char_encoder_top] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      err_count++;
   endtask

   // Gap length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Encode one byte: advance the group state and, if keep is set, queue the characters it closes
   function automatic void encode_byte(input byte_type d, input logic l, input bit keep);
      byte_type     grp [0:2];
      char_type     ch [0:3];
      int unsigned  n_bytes;
      int unsigned  k;
      enc_char_type item;
      if (grp_pos == 2'd0) begin
         grp[0] = d;
         grp[1] = '0;
         grp[2] = '0;
         n_bytes = 1;
      end else if (grp_pos == 2'd1) begin
         grp[0] = held_first;
         grp[1] = d;
         grp[2] = '0;
         n_bytes = 2;
      end else begin
         grp[0] = held_first;
         grp[1] = held_second;
         grp[2] = d;
         n_bytes = 3;
      end
      // hold the byte while the group is still filling
      if (n_bytes < 3 && !l) begin
         if (grp_pos == 2'd0)
            held_first = d;
         else
            held_second = d;
         grp_pos = grp_pos + 2'd1;
         return;
      end
      ch[0] = 7'h40 | char_type'(grp[0] >> 6) << 4 | char_type'(grp[1] >> 6) << 2
              | char_type'(grp[2] >> 6);
      if (at_start)
         ch[0] = ch[0] & 7'h3F;
      for (k = 1; k < 4; k++)
         ch[k] = 7'h40 | char_type'(grp[k-1] & 8'h3F);
      if (keep) begin
         for (k = 0; k <= n_bytes; k++) begin
            item.ch       = ch[k];
            item.run_last = (k == n_bytes);
            item.pkt_end  = (k == n_bytes) && l;
            pending_chars.push_back(item);
         end
      end
      grp_pos     = '0;
      held_first  = '0;
      held_second = '0;
      at_start    = l;
   endfunction

   // Offer one byte and hold it until the transfer
   task automatic send_byte(input byte_type d, input logic l);
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.last_byte <= l;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic idle_sender(input int unsigned n);
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected character has come
   task automatic drain_sender();
      req_chan.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // Byte source and predictor
   initial begin : drive_bytes
      int unsigned  pkt_len;
      int unsigned  sent;
      int unsigned  k;
      int unsigned  i;
      int unsigned  sel;
      byte_type     d;
      logic         l;
      enc_char_type item;
      char_type     typed_ch [0:3];

      req_chan.valid     <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.last_byte <= 1'b0;
      grp_pos     = '0;
      held_first  = '0;
      held_second = '0;
      at_start    = 1'b1;
      err_count   = 0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed rows
      for (i = 0; i < DIR_ROWS; i++) begin
         send_byte(dir_tab[i].data, dir_tab[i].last);
         encode_byte(dir_tab[i].data, dir_tab[i].last, !dir_tab[i].typed);
         if (dir_tab[i].typed) begin
            typed_ch[0] = dir_tab[i].c0;
            typed_ch[1] = dir_tab[i].c1;
            typed_ch[2] = dir_tab[i].c2;
            typed_ch[3] = dir_tab[i].c3;
            for (k = 0; k < dir_tab[i].n; k++) begin
               item.ch       = typed_ch[k];
               item.run_last = (k + 1 == dir_tab[i].n);
               item.pkt_end  = (k + 1 == dir_tab[i].n) && dir_tab[i].last;
               pending_chars.push_back(item);
            end
         end
         idle_sender(pick_gap());
      end
      drain_sender();

      // random packets, mostly short, a few long
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         pkt_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                               : $urandom_range(1, 7);
         for (k = 0; k < pkt_len; k++) begin
            sel = $urandom_range(0, 7);
            d = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : byte_type'($urandom);
            l = (k + 1 == pkt_len);
            send_byte(d, l);
            encode_byte(d, l, 1'b1);
            sent++;
            // pause mid-run until everything is out; keep a burst window gap-free
            if (sent == RANDOM_BYTES / 2)
               drain_sender();
            else if (sent < 120 || sent >= 160)
               idle_sender(pick_gap());
         end
      end

      drain_sender();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("[three_byte_to_four_char_encoder_top] OK");
      else
         $display("[three_byte_to_four_char_encoder_top] ERROR");
      $finish;
   end

   // Character sink: check each transfer and vary ready
   initial begin : take_chars
      enc_char_type want;
      int unsigned  hold_cnt;
      int unsigned  stall_cnt;
      bit           long_hold_done;

      rsp_chan.ready <= 1'b0;
      got_count      = 0;
      hold_cnt       = 0;
      stall_cnt      = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got_count++;
            if (pending_chars.size() == 0) begin
               report_mismatch("unexpected char", int'(rsp_chan.out_char), 0);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_chan.out_char !== want.ch)
                  report_mismatch("out_char", int'(rsp_chan.out_char), int'(want.ch));
               if (rsp_chan.run_last !== want.run_last)
                  report_mismatch("run_last", int'(rsp_chan.run_last),
                                  int'(want.run_last));
               if (rsp_chan.packet_end !== want.pkt_end)
                  report_mismatch("packet_end", int'(rsp_chan.packet_end),
                                  int'(want.pkt_end));
            end
         end
         // one long hold-off so the block backs up onto its input
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (!long_hold_done && got_count >= 60) begin
            long_hold_done = 1'b1;
            hold_cnt = LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_chan.ready <= 1'b0;
         end else if ((got_count / 80) % 3 != 1 && $urandom_range(0, 3) == 0) begin
            stall_cnt = pick_gap();
            rsp_chan.ready <= (stall_cnt == 0);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

endmodule

// File: files.f
rtl/tbfc_pkg.sv
rtl/tbfc_if.sv
rtl/tbfc_front.sv
rtl/tbfc_queue.sv
rtl/tbfc_back.sv
rtl/three_byte_to_four_char_encoder_top.sv
bench/tb.sv
